>>> design/iddp_pkg.sv
// Package for the image header dimension parser: scan phases, format codes,
// marker codes and the per-file scan state record. No dependencies.
package iddp_pkg;

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_MARKER = 3'd1,
    PH_SOF    = 3'd2,
    PH_LENHI  = 3'd3,
    PH_LENLO  = 3'd4,
    PH_DONE   = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  localparam logic [1:0] FMT_PNG  = 2'd0;
  localparam logic [1:0] FMT_JPEG = 2'd1;

  localparam logic [7:0] MARKER_PREFIX = 8'hFF;
  localparam logic [7:0] MARKER_SOF0   = 8'hC0;
  localparam logic [7:0] MARKER_SOF2   = 8'hC2;

  // SOF offsets counted from marker offset 2
  localparam logic [2:0] SOF_HEIGHT_HI = 3'd3;
  localparam logic [2:0] SOF_HEIGHT_LO = 3'd4;
  localparam logic [2:0] SOF_WIDTH_HI  = 3'd5;
  localparam logic [2:0] SOF_WIDTH_LO  = 3'd6;

  // PNG IHDR byte positions
  localparam int unsigned PNG_WIDTH_FIRST  = 16;
  localparam int unsigned PNG_HEIGHT_FIRST = 20;
  localparam int unsigned PNG_HEIGHT_LAST  = 23;
  localparam int unsigned JPEG_SCAN_START  = 2;

  localparam int unsigned OUT_TDATA_BITS = 72;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  offset;
    logic [15:0] skip;
    logic [7:0]  len_hi;
    logic [31:0] width;
    logic [31:0] height;
    logic        found;
  } scan_state_t;

endpackage

>>> design/image_header_dimension_parser_core.sv
// Image header dimension parser: one file byte per transaction, one result per file.
// Latency: the result is presented the cycle after the last byte is accepted.
// Throughput: one byte per cycle; the input stalls only while a result waits on out_tready.
// Reset (rst_n low, synchronous): scan state, position, result valid and image_format clear.
// After each last byte the scan state and position return to reset; image_format is kept.
// Depends on iddp_pkg and iddp_step.
module image_header_dimension_parser_core #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_wr_data,   // image_format
  // byte stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,      // [7:0] data_byte
  input  logic                                in_tlast,      // last_byte
  // result
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [iddp_pkg::OUT_TDATA_BITS-1:0] out_tdata      // [0] found, [32:1] image_width,
                                                             // [64:33] image_height, rest zero
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [1:0]               image_format_r;
  iddp_pkg::scan_state_t    state_r;
  iddp_pkg::scan_state_t    state_nxt;
  iddp_pkg::scan_state_t    step_nxt;
  logic [POSITION_BITS-1:0] position_r;
  logic [POSITION_BITS-1:0] position_nxt;
  logic                     out_valid_r;
  logic                     found_r;
  logic [31:0]              width_r;
  logic [31:0]              height_r;
  logic                     in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  iddp_step #(
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .cur          (state_r),
    .position     (position_r),
    .image_format (image_format_r),
    .data_byte    (in_tdata),
    .nxt          (step_nxt)
  );

  always_comb begin
    state_nxt    = state_r;
    position_nxt = position_r;
    if (in_accept) begin
      if (in_tlast) begin
        state_nxt    = '0;
        position_nxt = '0;
      end else begin
        state_nxt    = step_nxt;
        position_nxt = (position_r == POS_MAX) ? position_r : position_r + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_format_r <= 2'd0;
      state_r        <= '0;
      position_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        image_format_r <= cfg_wr_data;
      end
      state_r    <= state_nxt;
      position_r <= position_nxt;
      if (in_accept && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on the last byte, hold while stalled
  always_ff @(posedge clk) begin
    if (in_accept && in_tlast) begin
      found_r  <= step_nxt.found;
      width_r  <= step_nxt.found ? step_nxt.width  : 32'd0;
      height_r <= step_nxt.found ? step_nxt.height : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, height_r, width_r, found_r};

`ifndef NO_ASSERTIONS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> out_tvalid)
    else $error("last byte accepted without a result");

  a_last_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_tlast |=> position_r == '0 && state_r == '0)
    else $error("scan state not cleared after last byte");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !found_r |-> width_r == 32'd0 && height_r == 32'd0)
    else $error("dimensions nonzero without found");

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("input stalled with no pending result");
`endif

endmodule

>>> design/iddp_step.sv
// Next-state logic for one file byte: PNG IHDR capture and JPEG marker scan.
// Depends on iddp_pkg.
module iddp_step #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  iddp_pkg::scan_state_t    cur,
  input  logic [POSITION_BITS-1:0] position,
  input  logic [1:0]               image_format,
  input  logic [7:0]               data_byte,
  output iddp_pkg::scan_state_t    nxt
);

  logic        in_width_win;
  logic        in_height_win;
  logic        at_height_last;
  logic        jpeg_active;
  logic [15:0] seg_len;

  assign in_width_win   = (position >= POSITION_BITS'(iddp_pkg::PNG_WIDTH_FIRST)) &&
                          (position <  POSITION_BITS'(iddp_pkg::PNG_HEIGHT_FIRST));
  assign in_height_win  = (position >= POSITION_BITS'(iddp_pkg::PNG_HEIGHT_FIRST)) &&
                          (position <= POSITION_BITS'(iddp_pkg::PNG_HEIGHT_LAST));
  assign at_height_last = (position == POSITION_BITS'(iddp_pkg::PNG_HEIGHT_LAST));
  assign jpeg_active    = (position >= POSITION_BITS'(iddp_pkg::JPEG_SCAN_START));
  assign seg_len        = {cur.len_hi, data_byte};

  always_comb begin
    nxt = cur;
    if (image_format == iddp_pkg::FMT_PNG) begin
      if (in_width_win) begin
        nxt.width = {cur.width[23:0], data_byte};
      end else if (in_height_win) begin
        nxt.height = {cur.height[23:0], data_byte};
        if (at_height_last) begin
          nxt.found = 1'b1;
        end
      end
    end else if (image_format == iddp_pkg::FMT_JPEG && jpeg_active) begin
      case (cur.phase)
        iddp_pkg::PH_MARKER: begin
          if (data_byte == iddp_pkg::MARKER_SOF0 || data_byte == iddp_pkg::MARKER_SOF2) begin
            nxt.phase  = iddp_pkg::PH_SOF;
            nxt.offset = 3'd0;
          end else begin
            nxt.phase = iddp_pkg::PH_LENHI;
          end
        end
        iddp_pkg::PH_SOF: begin
          case (cur.offset)
            iddp_pkg::SOF_HEIGHT_HI: nxt.height = {16'd0, data_byte, 8'd0};
            iddp_pkg::SOF_HEIGHT_LO: nxt.height = {cur.height[31:8], data_byte};
            iddp_pkg::SOF_WIDTH_HI:  nxt.width  = {16'd0, data_byte, 8'd0};
            iddp_pkg::SOF_WIDTH_LO: begin
              nxt.width = {cur.width[31:8], data_byte};
              nxt.found = 1'b1;
              nxt.phase = iddp_pkg::PH_DONE;
            end
            default: ;
          endcase
          nxt.offset = cur.offset + 3'd1;
        end
        iddp_pkg::PH_LENHI: begin
          nxt.len_hi = data_byte;
          nxt.phase  = iddp_pkg::PH_LENLO;
        end
        iddp_pkg::PH_LENLO: begin
          // short or empty segment: resume seeking right after the length
          if (seg_len <= 16'd2) begin
            nxt.skip  = 16'd0;
            nxt.phase = iddp_pkg::PH_SEEK;
          end else begin
            nxt.skip  = seg_len - 16'd2;
            nxt.phase = iddp_pkg::PH_SKIP;
          end
        end
        iddp_pkg::PH_SKIP: begin
          if (cur.skip <= 16'd1) begin
            nxt.skip  = 16'd0;
            nxt.phase = iddp_pkg::PH_SEEK;
          end else begin
            nxt.skip = cur.skip - 16'd1;
          end
        end
        iddp_pkg::PH_DONE: ;
        default: begin
          nxt.phase = (data_byte == iddp_pkg::MARKER_PREFIX) ? iddp_pkg::PH_MARKER
                                                             : iddp_pkg::PH_SEEK;
        end
      endcase
    end
  end

endmodule
